// File: hw/rtl/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

  // field and store widths
  localparam int PIX_W      = 16;
  localparam int COORD_W    = 11;
  localparam int DIM_W      = 12;
  localparam int LEVEL_W    = 20;
  localparam int CSUM_W     = 18;
  localparam int WSUM_W     = 20;
  localparam int LEVEL_X_W  = 24;
  localparam int THR_W      = 28;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // frame geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int WINDOW     = 3;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);

  // detection list
  localparam int MAX_DET    = 64;
  localparam int DET_AW     = $clog2(MAX_DET);
  localparam int CNT_W      = DET_AW + 1;
  localparam int SEPARATION = 10;
  localparam int DET_W      = 2 * COORD_W;

  // register map, one 32-bit word per register
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BACKGROUND   = 2'd2,
    REG_NOISE        = 2'd3
  } reg_idx_t;

  // list check sequencer
  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCAN,
    ST_EMIT
  } scan_state_t;

  // clamp a size register into the supported range
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(WINDOW)) begin
      r = DIM_W'(WINDOW);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bsd_if.sv
`default_nettype none

// pixel channel
interface bsd_pix_if;
  logic                         valid;
  logic                         ready;
  logic [bsd_pkg::PIX_W-1:0]    pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// detection channel
interface bsd_det_if;
  logic                         valid;
  logic                         ready;
  logic [bsd_pkg::COORD_W-1:0]  det_x;
  logic [bsd_pkg::COORD_W-1:0]  det_y;
  logic                         dropped;

  modport source (output valid, output det_x, output det_y, output dropped, input ready);
  modport sink   (input valid, input det_x, input det_y, input dropped, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/box_sum_star_detector_unit.sv
// Streaming 3x3 box-sum star detector.
// in_pix takes 16-bit pixels in raster order, one word per cycle with
// valid/ready. out_det gives one word per kept hit: the window's right
// column, its top row and a dropped flag (list full, hit not stored).
// The cfg_ APB port holds width, height, background and noise (Q16.4);
// writing width or height restarts the frame. Write registers only while
// the block is idle; after a write the threshold is rebuilt in lvl_r, then thr_r.
// A pixel passes the line store read (stage a), then the column and window
// sums (stage b), and then its hit test; a pixel without a hit is not held,
// so the pixel rate is one per clock while no hit is being checked.
// A hit holds the pipeline while the detection list (one read port, one
// entry per cycle) is checked against the detections stored in the frame
// (at most 64) until a near one is found. A kept hit then waits in ST_EMIT
// until the output register that drives out_det is free.
// The result sits in an output register; a stalled receiver holds only the
// next hit, plain pixels keep flowing until a second hit has to wait.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// counters and list count and empties the pipeline; no clearing pass runs.
`default_nettype none

module box_sum_star_detector_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  bsd_pix_if.sink                          in_pix,
  bsd_det_if.source                        out_det,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [bsd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire  [bsd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bsd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  // configuration registers
  logic [bsd_pkg::DIM_W-1:0]     width_r, height_r;
  logic [bsd_pkg::LEVEL_W-1:0]   bg_r, noise_r;
  logic                          cfg_wr;
  logic                          restart;
  bsd_pkg::reg_idx_t             cfg_idx;

  // threshold pipeline
  logic [bsd_pkg::LEVEL_X_W-1:0] lvl_r;
  logic [bsd_pkg::THR_W-1:0]     thr_r;

  // raster counters
  logic [bsd_pkg::DIM_W-1:0]     w_eff, h_eff;
  logic [bsd_pkg::COORD_W-1:0]   col_r, row_r;
  logic [bsd_pkg::DIM_W-1:0]     col_inc, row_inc;

  // stage a: line store read in flight
  logic                          a_valid_r;
  logic [bsd_pkg::PIX_W-1:0]     a_pix_r;
  logic [bsd_pkg::COORD_W-1:0]   a_col_r, a_row_r;
  logic                          in_acc;
  logic                          adv;

  // line store: upper half two rows up, lower half one row up
  logic [2*bsd_pkg::PIX_W-1:0]   line_mem [bsd_pkg::MAX_WIDTH];
  logic [2*bsd_pkg::PIX_W-1:0]   line_q;
  logic [bsd_pkg::PIX_W-1:0]     above1, above2;
  logic [bsd_pkg::CSUM_W-1:0]    col_sum;

  // column sums and stage b
  logic [bsd_pkg::CSUM_W-1:0]    cs0_r, cs1_r, cs2_r;
  logic [bsd_pkg::WSUM_W-1:0]    win_r;
  logic                          b_valid_r, b_full_r, b_fs_r;
  logic [bsd_pkg::COORD_W-1:0]   b_x_r, b_y_r;
  logic                          b_hit;
  logic                          b_take;

  // detection list and check sequencer
  logic [bsd_pkg::DET_W-1:0]     det_mem [bsd_pkg::MAX_DET];
  logic [bsd_pkg::DET_W-1:0]     det_q;
  bsd_pkg::scan_state_t          state_r, state_nxt;
  logic [bsd_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bsd_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic                          qv_r, qv_nxt;
  logic                          det_rd, det_wr;
  logic                          near;
  logic [bsd_pkg::COORD_W-1:0]   ex, ey, dx, dy;
  logic                          out_free, out_load, list_full;

  // output register
  logic                          out_valid_r;
  logic [bsd_pkg::COORD_W-1:0]   out_x_r, out_y_r;
  logic                          out_drop_r;

  // apb decode
  assign cfg_pready = 1'b1;
  assign cfg_idx    = bsd_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign restart    = cfg_wr && (cfg_idx == bsd_pkg::REG_IMAGE_WIDTH ||
                                 cfg_idx == bsd_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bsd_pkg::DIM_W'(bsd_pkg::MAX_WIDTH);
      height_r <= bsd_pkg::DIM_W'(bsd_pkg::MAX_HEIGHT);
      bg_r     <= '0;
      noise_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bsd_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[bsd_pkg::DIM_W-1:0];
        bsd_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[bsd_pkg::DIM_W-1:0];
        bsd_pkg::REG_BACKGROUND:   bg_r     <= cfg_pwdata[bsd_pkg::LEVEL_W-1:0];
        bsd_pkg::REG_NOISE:        noise_r  <= cfg_pwdata[bsd_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      bsd_pkg::REG_IMAGE_WIDTH:  cfg_prdata = bsd_pkg::CFG_DATA_W'(width_r);
      bsd_pkg::REG_IMAGE_HEIGHT: cfg_prdata = bsd_pkg::CFG_DATA_W'(height_r);
      bsd_pkg::REG_BACKGROUND:   cfg_prdata = bsd_pkg::CFG_DATA_W'(bg_r);
      bsd_pkg::REG_NOISE:        cfg_prdata = bsd_pkg::CFG_DATA_W'(noise_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // threshold 9*(background + 10*noise), two registered steps
  always_ff @(posedge clk) begin
    lvl_r <= bsd_pkg::LEVEL_X_W'(bg_r)
           + (bsd_pkg::LEVEL_X_W'(noise_r) << 3)
           + (bsd_pkg::LEVEL_X_W'(noise_r) << 1);
    thr_r <= (bsd_pkg::THR_W'(lvl_r) << 3) + bsd_pkg::THR_W'(lvl_r);
  end

  // raster position of the next pixel
  assign w_eff   = bsd_pkg::clamp_dim(width_r,  bsd_pkg::DIM_W'(bsd_pkg::MAX_WIDTH));
  assign h_eff   = bsd_pkg::clamp_dim(height_r, bsd_pkg::DIM_W'(bsd_pkg::MAX_HEIGHT));
  assign col_inc = bsd_pkg::DIM_W'(col_r) + 1'b1;
  assign row_inc = bsd_pkg::DIM_W'(row_r) + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_r <= '0;
        row_r <= (row_inc >= h_eff) ? '0 : row_inc[bsd_pkg::COORD_W-1:0];
      end else begin
        col_r <= col_inc[bsd_pkg::COORD_W-1:0];
      end
    end
  end

  // pipeline handshake
  assign adv          = !b_valid_r || b_take;
  assign in_pix.ready = !a_valid_r || adv;
  assign in_acc       = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_pix.ready) begin
        a_valid_r <= in_acc;
      end
      if (adv) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pix_r <= in_pix.pixel_value;
      a_col_r <= col_r;
      a_row_r <= row_r;
    end
  end

  // line store: read on accept, write back when the pixel moves on
  assign above1  = line_q[bsd_pkg::PIX_W-1:0];
  assign above2  = line_q[2*bsd_pkg::PIX_W-1:bsd_pkg::PIX_W];
  assign col_sum = bsd_pkg::CSUM_W'(above1) + bsd_pkg::CSUM_W'(above2)
                 + bsd_pkg::CSUM_W'(a_pix_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_q <= line_mem[col_r];
    end
    if (a_valid_r && adv) begin
      line_mem[a_col_r] <= {above1, a_pix_r};
    end
  end

  // column sums and box sum
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      cs0_r <= '0;
      cs1_r <= '0;
      cs2_r <= '0;
      win_r <= '0;
    end else if (a_valid_r && adv) begin
      cs2_r <= cs1_r;
      cs1_r <= cs0_r;
      cs0_r <= col_sum;
      win_r <= bsd_pkg::WSUM_W'(col_sum) + bsd_pkg::WSUM_W'(cs0_r)
             + bsd_pkg::WSUM_W'(cs1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && adv) begin
      b_x_r    <= a_col_r;
      b_y_r    <= a_row_r - bsd_pkg::COORD_W'(bsd_pkg::WINDOW - 1);
      b_full_r <= (a_row_r >= bsd_pkg::COORD_W'(bsd_pkg::WINDOW - 1)) &&
                  (a_col_r >= bsd_pkg::COORD_W'(bsd_pkg::WINDOW - 1));
      b_fs_r   <= (a_row_r == '0) && (a_col_r == '0);
    end
  end

  // hit test: 16*sum against the threshold
  assign b_hit = b_full_r &&
                 ((bsd_pkg::THR_W'(win_r) << 4) > thr_r);

  // distance to the list entry just read
  assign ex   = det_q[bsd_pkg::DET_W-1:bsd_pkg::COORD_W];
  assign ey   = det_q[bsd_pkg::COORD_W-1:0];
  assign dx   = (b_x_r >= ex) ? b_x_r - ex : ex - b_x_r;
  assign dy   = (b_y_r >= ey) ? b_y_r - ey : ey - b_y_r;
  assign near = (dx < bsd_pkg::COORD_W'(bsd_pkg::SEPARATION)) ||
                (dy < bsd_pkg::COORD_W'(bsd_pkg::SEPARATION));

  assign out_free  = !out_valid_r || out_det.ready;
  assign list_full = (cnt_r >= bsd_pkg::CNT_W'(bsd_pkg::MAX_DET));

  // check sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsd_pkg::ST_RUN;
      cnt_r   <= '0;
      idx_r   <= '0;
      qv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= restart ? '0 : cnt_nxt;
      idx_r   <= idx_nxt;
      qv_r    <= qv_nxt;
    end
  end

  // next state: pass plain pixels, scan the list for a hit, then emit it unless an entry is near
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    qv_nxt    = 1'b0;
    det_rd    = 1'b0;
    det_wr    = 1'b0;
    out_load  = 1'b0;
    b_take    = 1'b0;
    case (state_r)
      bsd_pkg::ST_RUN: begin
        if (b_valid_r && b_hit) begin
          state_nxt = bsd_pkg::ST_SCAN;
          idx_nxt   = '0;
        end else if (b_valid_r) begin
          b_take = 1'b1;
          if (b_fs_r) begin
            cnt_nxt = '0;
          end
        end
      end
      bsd_pkg::ST_SCAN: begin
        if (qv_r && near) begin
          b_take    = 1'b1;
          state_nxt = bsd_pkg::ST_RUN;
        end else if (idx_r < cnt_r) begin
          det_rd  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          qv_nxt  = 1'b1;
        end else if (!qv_r) begin
          state_nxt = bsd_pkg::ST_EMIT;
        end
      end
      bsd_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          b_take    = 1'b1;
          state_nxt = bsd_pkg::ST_RUN;
          if (!list_full) begin
            det_wr  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = bsd_pkg::ST_RUN;
      end
    endcase
  end

  // detection list store
  always_ff @(posedge clk) begin
    if (det_rd) begin
      det_q <= det_mem[idx_r[bsd_pkg::DET_AW-1:0]];
    end
    if (det_wr) begin
      det_mem[cnt_r[bsd_pkg::DET_AW-1:0]] <= {b_x_r, b_y_r};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_det.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= b_x_r;
      out_y_r    <= b_y_r;
      out_drop_r <= list_full;
    end
  end

  assign out_det.valid   = out_valid_r;
  assign out_det.det_x   = out_x_r;
  assign out_det.det_y   = out_y_r;
  assign out_det.dropped = out_drop_r;

endmodule

`default_nettype wire
